// File: hdl/four_level_page_table_mapper_core_assert.svh
// assertion macros for the page table mapper checker
// used by pgmap_chk; clock aclk and reset aresetn must be in scope
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_CORE_ASSERT_SVH

// implication checked outside reset
`define PGMAP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pgmap assertion failed");

// next-cycle implication checked also across reset
`define PGMAP_ASSERT_NEXT_RAW(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pgmap assertion failed");

// next-cycle implication checked outside reset
`define PGMAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pgmap assertion failed");

`endif

// File: hdl/pgmap_pkg.sv
// shared types, constants and microcode table of the page table mapper
// no dependencies
package pgmap_pkg;

    localparam int POOL_TABLES_DEF = 128;
    localparam int TABLE_ENTRIES   = 512;
    localparam int LEVEL_W         = 9;
    localparam int VPAGE_W         = 36;
    localparam int FRAME_W         = 40;
    localparam int ENTRY_W         = FRAME_W + 2;
    localparam int FLAG_PRESENT    = 0;
    localparam int TOP_LEVEL       = 3;
    localparam logic [1:0] ENTRY_FLAGS = 2'b11;  // writable, present

    // result status codes
    localparam logic STATUS_MAPPED    = 1'b0;
    localparam logic STATUS_NO_TABLES = 1'b1;

    typedef enum logic [2:0] {
        STEP_CLR,
        STEP_IDLE,
        STEP_READ,
        STEP_EVAL,
        STEP_LEAF,
        STEP_DONE
    } step_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_IDLE,
        OP_READ,
        OP_EVAL,
        OP_LEAF,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_CLR_LAST,
        COND_IN_XFER,
        COND_LEAF_LEVEL,
        COND_FAIL,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic in_xfer;
        logic leaf_level;
        logic fail;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t ucode(input step_t addr);
        ctrl_t word;
        unique case (addr)
            STEP_CLR:  word = '{OP_CLEAR, COND_CLR_LAST,   STEP_IDLE, STEP_CLR};
            STEP_IDLE: word = '{OP_IDLE,  COND_IN_XFER,    STEP_READ, STEP_IDLE};
            STEP_READ: word = '{OP_READ,  COND_LEAF_LEVEL, STEP_LEAF, STEP_EVAL};
            STEP_EVAL: word = '{OP_EVAL,  COND_FAIL,       STEP_DONE, STEP_READ};
            STEP_LEAF: word = '{OP_LEAF,  COND_NONE,       STEP_LEAF, STEP_DONE};
            STEP_DONE: word = '{OP_DONE,  COND_OUT_BUSY,   STEP_DONE, STEP_IDLE};
            default:   word = '{OP_IDLE,  COND_NONE,       STEP_IDLE, STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

// File: hdl/pgmap_ram.sv
// generic single-port ram with registered read
// no dependencies
module pgmap_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pgmap_seq.sv
// microcode sequencer: step counter, control rom lookup, conditional jumps
// depends on pgmap_pkg
module pgmap_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  pgmap_pkg::flags_t flags,
    output pgmap_pkg::ctrl_t  ctrl
);

    pgmap_pkg::step_t step_reg;
    pgmap_pkg::step_t step_next;
    pgmap_pkg::ctrl_t word;
    logic             taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pgmap_pkg::STEP_CLR;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        word = pgmap_pkg::ucode(step_reg);
        unique case (word.cond)
            pgmap_pkg::COND_NONE:       taken = 1'b0;
            pgmap_pkg::COND_CLR_LAST:   taken = flags.clr_last;
            pgmap_pkg::COND_IN_XFER:    taken = flags.in_xfer;
            pgmap_pkg::COND_LEAF_LEVEL: taken = flags.leaf_level;
            pgmap_pkg::COND_FAIL:       taken = flags.fail;
            pgmap_pkg::COND_OUT_BUSY:   taken = flags.out_busy;
            default:                    taken = 1'b0;
        endcase
        step_next = taken ? word.jump : word.next;
    end

    assign ctrl = word;

endmodule

// File: hdl/four_level_page_table_mapper_core.sv
// Four-level page table mapper. Each request walks root, second and third
// level entries, taking a cleared table from the pool for every entry not
// present, then writes the leaf with the frame. One request is in work at a
// time: a fully mapped request passes through the accepting step, a read and
// its check for each of the three table levels through the single table
// memory port, the leaf read, the leaf write and the result step before the
// next acceptance; a check that finds the pool run out goes straight to the
// result step, and the result step waits for as long as an earlier result
// is still held. A result waits in an output register while the next request
// is taken. After reset the table store is swept clear, one entry per cycle,
// all (POOL_TABLES+1)*512 entries, before the first request is accepted.
// depends on pgmap_pkg, pgmap_seq, pgmap_ram
module four_level_page_table_mapper_core #(
    parameter int POOL_TABLES = pgmap_pkg::POOL_TABLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pgmap_pkg::VPAGE_W-1:0] s_virtual_page,
    input  logic [pgmap_pkg::FRAME_W-1:0] s_physical_frame,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [1:0]                    m_new_tables,
    output logic [7:0]                    m_tables_in_use,
    output logic [pgmap_pkg::VPAGE_W-1:0] m_invalidate_page
);

    localparam int TBL_W  = $clog2(POOL_TABLES + 1);
    localparam int DEPTH  = (POOL_TABLES + 1) * pgmap_pkg::TABLE_ENTRIES;
    localparam int ADDR_W = TBL_W + pgmap_pkg::LEVEL_W;
    localparam int EW     = pgmap_pkg::ENTRY_W;
    localparam int FW     = pgmap_pkg::FRAME_W;
    localparam int VW     = pgmap_pkg::VPAGE_W;

    pgmap_pkg::ctrl_t  ctrl;
    pgmap_pkg::flags_t flags;

    logic [VW-1:0]     vpage_reg, vpage_next;
    logic [FW-1:0]     frame_reg, frame_next;
    logic [TBL_W-1:0]  row_reg, row_next;
    logic [1:0]        level_reg, level_next;
    logic [TBL_W-1:0]  free_reg, free_next;
    logic [1:0]        fresh_reg, fresh_next;
    logic              status_reg, status_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [1:0]        m_new_reg, m_new_next;
    logic [7:0]        m_use_reg, m_use_next;
    logic [VW-1:0]     m_page_reg, m_page_next;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_addr;
    logic [EW-1:0]                ram_wdata;
    logic [EW-1:0]                ram_rdata;
    logic [pgmap_pkg::LEVEL_W-1:0] idx;
    logic                         present;
    logic [FW-1:0]                ptr;
    logic                         eval_fail;
    logic [TBL_W-1:0]             next_row;
    logic [TBL_W+7:0]             use_ext;
    logic                         in_xfer;
    logic                         out_busy;

    pgmap_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    pgmap_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_ready  = (ctrl.op == pgmap_pkg::OP_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;

    assign idx       = vpage_reg[level_reg * pgmap_pkg::LEVEL_W +: pgmap_pkg::LEVEL_W];
    assign present   = ram_rdata[pgmap_pkg::FLAG_PRESENT];
    assign ptr       = ram_rdata[EW-1:2];
    assign eval_fail = present ? (ptr >= FW'(POOL_TABLES))
                               : (free_reg >= TBL_W'(POOL_TABLES));
    assign next_row  = present ? (ptr[TBL_W-1:0] + TBL_W'(1)) : (free_reg + TBL_W'(1));
    assign use_ext   = {8'b0, free_reg};

    assign flags.clr_last   = (clr_reg == ADDR_W'(DEPTH - 1));
    assign flags.in_xfer    = in_xfer;
    assign flags.leaf_level = (level_reg == 2'd0);
    assign flags.fail       = eval_fail;
    assign flags.out_busy   = out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            clr_reg     <= clr_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
        vpage_reg    <= vpage_next;
        frame_reg    <= frame_next;
        row_reg      <= row_next;
        level_reg    <= level_next;
        fresh_reg    <= fresh_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_new_reg    <= m_new_next;
        m_use_reg    <= m_use_next;
        m_page_reg   <= m_page_next;
    end

    always_comb begin
        vpage_next    = vpage_reg;
        frame_next    = frame_reg;
        row_next      = row_reg;
        level_next    = level_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        status_next   = status_reg;
        clr_next      = clr_reg;
        m_status_next = m_status_reg;
        m_new_next    = m_new_reg;
        m_use_next    = m_use_reg;
        m_page_next   = m_page_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_addr      = {row_reg, idx};
        ram_wdata     = {frame_reg, pgmap_pkg::ENTRY_FLAGS};

        unique case (ctrl.op)
            pgmap_pkg::OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
            end
            pgmap_pkg::OP_IDLE: begin
                if (in_xfer) begin
                    vpage_next  = s_virtual_page;
                    frame_next  = s_physical_frame;
                    row_next    = '0;
                    level_next  = 2'(pgmap_pkg::TOP_LEVEL);
                    fresh_next  = 2'd0;
                    status_next = pgmap_pkg::STATUS_MAPPED;
                end
            end
            pgmap_pkg::OP_READ: begin
                ram_we = 1'b0;
            end
            pgmap_pkg::OP_EVAL: begin
                if (eval_fail) begin
                    status_next = pgmap_pkg::STATUS_NO_TABLES;
                end else begin
                    row_next   = next_row;
                    level_next = level_reg - 2'd1;
                    if (!present) begin
                        // link a fresh pool table
                        ram_we     = 1'b1;
                        ram_wdata  = {{(FW - TBL_W){1'b0}}, free_reg, pgmap_pkg::ENTRY_FLAGS};
                        free_next  = free_reg + TBL_W'(1);
                        fresh_next = fresh_reg + 2'd1;
                    end
                end
            end
            pgmap_pkg::OP_LEAF: begin
                ram_we = 1'b1;
            end
            pgmap_pkg::OP_DONE: begin
                if (!out_busy) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_new_next    = fresh_reg;
                    m_use_next    = use_ext[7:0];
                    m_page_next   = vpage_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_new_tables      = m_new_reg;
    assign m_tables_in_use   = m_use_reg;
    assign m_invalidate_page = m_page_reg;

endmodule

// File: hdl/pgmap_chk.sv
// port-level checker for the page table mapper, bound to the top level
// depends on four_level_page_table_mapper_core_assert.svh
`include "four_level_page_table_mapper_core_assert.svh"

module pgmap_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [35:0] s_virtual_page,
    input logic [39:0] s_physical_frame,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic [1:0]  m_new_tables,
    input logic [7:0]  m_tables_in_use,
    input logic [35:0] m_invalidate_page
);

    // result held while stalled
    `PGMAP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_new_tables) && $stable(m_tables_in_use) && $stable(m_invalidate_page))

    // one request in work at a time
    `PGMAP_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

    // clearing sweep blocks requests right after reset
    `PGMAP_ASSERT_NEXT_RAW(a_clear_after_reset, !aresetn, !s_ready)

    // a new result appears only once the sequencer is back to idle
    `PGMAP_ASSERT(a_result_then_idle, $rose(m_valid), s_ready)

endmodule

bind four_level_page_table_mapper_core pgmap_chk u_pgmap_chk (.*);
